@@ hdl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// Depends on nothing; every other file of the block imports it.
package spq_pkg;

   localparam int DEPTH          = 16;
   localparam int VALUE_WIDTH    = 32;
   localparam int PRIORITY_WIDTH = 16;
   localparam int COUNT_WIDTH    = $clog2(DEPTH + 1);
   localparam int CAP_WIDTH      = 5;

   // Operation codes carried in the cmd field
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // Capacity in effect after reset
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(DEPTH);

   // One stored entry
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]    value;
      logic signed [PRIORITY_WIDTH-1:0] prio;
   } slot_type;

   // Per-cycle control handed from the top level to each cell
   typedef struct packed {
      logic do_insert;
      logic do_remove;
      logic occupied;
   } cell_ctrl_type;

endpackage

@@ hdl/spq_interfaces.sv @@
// Channel interfaces of the sorted priority queue: request, response and CSR write.
// Depends on spq_pkg for field widths.
interface spq_req_if import spq_pkg::*; ();
   logic                             valid;
   logic                             ready;
   logic                             cmd;
   logic signed [VALUE_WIDTH-1:0]    item_value;
   logic signed [PRIORITY_WIDTH-1:0] item_priority;

   modport source (output valid, cmd, item_value, item_priority, input ready);
   modport sink   (input valid, cmd, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic signed [VALUE_WIDTH-1:0] head_value;
   logic [COUNT_WIDTH-1:0]        entry_count;

   modport source (output valid, ok, head_value, entry_count, input ready);
   modport sink   (input valid, ok, head_value, entry_count, output ready);
endinterface

interface spq_csr_if import spq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CAP_WIDTH-1:0] max_entries;

   modport source (output valid, max_entries, input ready);
   modport sink   (input valid, max_entries, output ready);
endinterface

@@ hdl/sorted_priority_queue.sv @@
// Sorted priority queue: a row of spq_cell slots kept in descending priority order.
// Depends on spq_pkg, spq_interfaces (spq_req_if, spq_rsp_if, spq_csr_if) and spq_cell.
//
// Usage:
//   req: one transfer is one operation. cmd CMD_INSERT stores item_value with
//        item_priority behind every entry of greater or equal priority; cmd
//        CMD_REMOVE takes the head entry out.
//   rsp: exactly one transfer per request: ok, head_value (the removed value on a
//        successful remove, zero otherwise) and entry_count after the operation.
//        An insert when the count has reached the capacity, or a remove on an
//        empty queue, gives ok low and leaves the contents alone.
//   csr: writes max_entries, the capacity in use (values above 16 act as 16).
//        Write only while no operation is outstanding.
// Latency: the response is valid the cycle after the request transfer.
// Throughput: one operation per cycle while rsp accepts; all cells compare and shift
//   in parallel in the transfer cycle, and the registered response frees the input.
// Stall: while rsp is held with ready low, req.ready stays low once the response
//   register is full; nothing is lost.
// Reset: synchronous; empties the queue (count zero), sets the capacity to 16 and
//   drops any pending response. Slot contents are not cleared.
module sorted_priority_queue import spq_pkg::*; (
   input logic        clock,
   input logic        reset,
   spq_req_if.sink    req,
   spq_rsp_if.source  rsp,
   spq_csr_if.sink    csr
);

   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic [CAP_WIDTH-1:0]          cap_ff;
   logic                          rsp_valid_ff;
   logic                          ok_ff, ok_in;
   logic signed [VALUE_WIDTH-1:0] head_ff, head_in;

   logic                   accept;
   logic                   has_room;
   logic                   do_insert, do_remove;
   logic [COUNT_WIDTH:0]   cap_eff;
   slot_type               new_slot;
   slot_type               slots [DEPTH];
   logic                   keeps [DEPTH];

   // Capacity register; writes always land at once
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr.valid) begin
         cap_ff <= csr.max_entries;
      end
   end

   // Clamp capacity to the number of cells
   always_comb begin
      if ({1'b0, cap_ff} > (CAP_WIDTH + 1)'(DEPTH)) begin
         cap_eff = (COUNT_WIDTH + 1)'(DEPTH);
      end else begin
         cap_eff = (COUNT_WIDTH + 1)'(cap_ff);
      end
   end

   // Take a request whenever the response register is free or draining
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign has_room  = ({1'b0, count_ff} < cap_eff);
   assign do_insert = accept && (req.cmd == CMD_INSERT) && has_room;
   assign do_remove = accept && (req.cmd == CMD_REMOVE) && (count_ff != '0);

   assign new_slot.value = req.item_value;
   assign new_slot.prio  = req.item_priority;

   // Row of cells; the head sits in cell 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      slot_type      left_slot;
      slot_type      right_slot;
      logic          left_keeps;

      assign ctrl.do_insert = do_insert;
      assign ctrl.do_remove = do_remove;
      assign ctrl.occupied  = (COUNT_WIDTH'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_slot  = new_slot;
         assign left_keeps = 1'b1;
      end else begin : g_inner
         assign left_slot  = slots[i-1];
         assign left_keeps = keeps[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_slot = slots[i];
      end else begin : g_notlast
         assign right_slot = slots[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .new_slot   (new_slot),
         .left_slot  (left_slot),
         .right_slot (right_slot),
         .left_keeps (left_keeps),
         .slot       (slots[i]),
         .keeps      (keeps[i])
      );
   end

   // Next count and response payload
   always_comb begin
      count_in = count_ff;
      ok_in    = 1'b0;
      head_in  = '0;
      if (do_insert) begin
         count_in = count_ff + COUNT_WIDTH'(1);
         ok_in    = 1'b1;
      end else if (do_remove) begin
         count_in = count_ff - COUNT_WIDTH'(1);
         ok_in    = 1'b1;
         head_in  = slots[0].value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Load the response register on each request transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff   <= ok_in;
         head_ff <= head_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.ok          = ok_ff;
   assign rsp.head_value  = head_ff;
   assign rsp.entry_count = count_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      ({1'b0, count_ff} <= (COUNT_WIDTH + 1)'(DEPTH)))
      else $error("entry count above depth");

   a_remove_ok : assert property (@(posedge clock) disable iff (reset)
      (accept && (req.cmd == CMD_REMOVE) && (count_ff != '0)) |=>
      (rsp.valid && rsp.ok && (rsp.entry_count == $past(count_ff) - COUNT_WIDTH'(1))))
      else $error("remove on non-empty queue did not report success");

   a_full_reject : assert property (@(posedge clock) disable iff (reset)
      (accept && (req.cmd == CMD_INSERT) && !has_room) |=>
      (rsp.valid && !rsp.ok && (count_ff == $past(count_ff))))
      else $error("insert beyond capacity was not rejected");

   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ok) |-> (rsp.head_value == '0))
      else $error("failed operation returned nonzero value");
`endif

endmodule

@@ hdl/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg for slot_type and cell_ctrl_type.
module spq_cell import spq_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  slot_type      new_slot,
   input  slot_type      left_slot,
   input  slot_type      right_slot,
   input  logic          left_keeps,
   output slot_type      slot,
   output logic          keeps
);

   slot_type slot_ff;
   slot_type slot_in;

   // An occupied cell stays in place when its stored priority is at least the incoming one
   assign keeps = ctrl.occupied &&
                  ($signed(slot_ff.prio) >= $signed(new_slot.prio));

   // Hold, take the new entry, shift right on insert, or shift left on remove
   always_comb begin
      slot_in = slot_ff;
      if (ctrl.do_insert) begin
         if (keeps) begin
            slot_in = slot_ff;
         end else if (left_keeps) begin
            slot_in = new_slot;
         end else begin
            slot_in = left_slot;
         end
      end else if (ctrl.do_remove) begin
         slot_in = right_slot;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot = slot_ff;

endmodule

@@ tb/sv/sorted_priority_queue_tb.sv @@
`timescale 1ns / 100ps
// Testbench for sorted_priority_queue: directed and random insert/remove traffic,
// checked transfer by transfer against a shadow copy of the sorted queue.
// Depends on spq_pkg, spq_interfaces and the sorted_priority_queue RTL.
module sorted_priority_queue_tb;
   import spq_pkg::*;

   // One predicted response
   typedef struct {
      logic                          ok;
      logic signed [VALUE_WIDTH-1:0] head_value;
      logic [COUNT_WIDTH-1:0]        entry_count;
   } queue_result_type;

   logic clock;
   logic reset = 1'b1;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();
   spq_csr_if csr_bus ();

   sorted_priority_queue i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // Shadow of the queue contents and the capacity register
   logic signed [VALUE_WIDTH-1:0]    shadow_values [DEPTH];
   logic signed [PRIORITY_WIDTH-1:0] shadow_prios  [DEPTH];
   int                               shadow_count;
   int                               shadow_capacity;

   queue_result_type pending_results [$];
   int               error_count;

   // Sender pacing
   int burst_left;
   bit steady_sender;
   bit req_raised;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Work out the response of one operation and advance the shadow queue
   function automatic queue_result_type apply_queue_op(
      input logic                             cmd,
      input logic signed [VALUE_WIDTH-1:0]    value,
      input logic signed [PRIORITY_WIDTH-1:0] prio
   );
      queue_result_type res;
      int               limit;
      int               pos;
      res.ok         = 1'b0;
      res.head_value = '0;
      limit = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
      if (cmd == CMD_INSERT) begin
         if (shadow_count < limit) begin
            // Slide lower priorities back; equal priorities stay ahead
            pos = shadow_count;
            while (pos > 0 && shadow_prios[pos-1] < prio) begin
               shadow_values[pos] = shadow_values[pos-1];
               shadow_prios[pos]  = shadow_prios[pos-1];
               pos--;
            end
            shadow_values[pos] = value;
            shadow_prios[pos]  = prio;
            shadow_count++;
            res.ok = 1'b1;
         end
      end else if (shadow_count > 0) begin
         res.head_value = shadow_values[0];
         for (int k = 0; k + 1 < shadow_count; k++) begin
            shadow_values[k] = shadow_values[k+1];
            shadow_prios[k]  = shadow_prios[k+1];
         end
         shadow_count--;
         res.ok = 1'b1;
      end
      res.entry_count = COUNT_WIDTH'(shadow_count);
      return res;
   endfunction

   // Lower the request valid once, only if it is up
   task automatic drop_req();
      if (req_raised) begin
         req_bus.valid <= 1'b0;
         req_raised = 1'b0;
      end
   endtask

   // Send one operation; returns at the edge of its transfer
   task automatic send_op(
      input logic                             cmd,
      input logic signed [VALUE_WIDTH-1:0]    value,
      input logic signed [PRIORITY_WIDTH-1:0] prio
   );
      int gap;
      if (burst_left == 0) begin
         burst_left = steady_sender ? 1_000_000 : $urandom_range(1, 24);
         gap = $urandom_range(1, 6);
         drop_req();
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= cmd;
      req_bus.item_value    <= value;
      req_bus.item_priority <= prio;
      req_raised = 1'b1;
      // Inputs change only at rising edges, so ready seen here holds at the next one
      do @(negedge clock); while (!req_bus.ready);
      pending_results.push_back(apply_queue_op(cmd, value, prio));
      @(posedge clock);
   endtask

   // Hold off the sender until every expected response has arrived
   task automatic wait_drained();
      drop_req();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write the capacity register while the queue is idle
   task automatic write_capacity(input logic [CAP_WIDTH-1:0] cap);
      wait_drained();
      csr_bus.valid       <= 1'b1;
      csr_bus.max_entries <= cap;
      do @(negedge clock); while (!csr_bus.ready);
      shadow_capacity = cap;
      @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Remove from an empty queue right after reset
   task automatic test_empty_remove();
      send_op(CMD_REMOVE, 32'sh0BAD_F00D, 16'sh5A5A);
   endtask

   // Extreme values and priorities, ties at the top and in the middle
   task automatic test_order_and_ties();
      send_op(CMD_INSERT, 32'sh7FFF_FFFF, 16'sh7FFF);
      send_op(CMD_INSERT, 32'sh8000_0000, 16'sh8000);
      send_op(CMD_INSERT, 32'sh0000_0000, 16'sh0000);
      send_op(CMD_INSERT, -32'sd1,        -16'sd1);
      send_op(CMD_INSERT, 32'sh1234_5678, 16'sh0000);
      send_op(CMD_INSERT, -32'sd5,        16'sh7FFF);
      repeat (7) send_op(CMD_REMOVE, '1, '1);
   endtask

   // Zero capacity, capacity of one, capacity above depth, capacity lowered below count
   task automatic test_capacity_limits();
      write_capacity('0);
      send_op(CMD_INSERT, 32'sd11, 16'sd3);
      send_op(CMD_REMOVE, '0, '0);
      write_capacity(CAP_WIDTH'(1));
      send_op(CMD_INSERT, 32'sd22, 16'sd4);
      send_op(CMD_INSERT, 32'sd33, 16'sd9);
      write_capacity('1);
      send_op(CMD_INSERT, 32'sd44, 16'sd9);
      write_capacity(CAP_WIDTH'(1));
      send_op(CMD_INSERT, 32'sd55, 16'sd1);
      send_op(CMD_REMOVE, '0, '0);
      send_op(CMD_REMOVE, '0, '0);
      write_capacity(CAP_WIDTH'(DEPTH + 1));
      send_op(CMD_INSERT, 32'sd66, -16'sd7);
      send_op(CMD_REMOVE, '0, '0);
   endtask

   // Phases of random traffic, each under its own capacity and insert/remove mix
   task automatic test_random_traffic();
      int                               fill_pct;
      int                               kind;
      logic                             cmd;
      logic signed [VALUE_WIDTH-1:0]    value;
      logic signed [PRIORITY_WIDTH-1:0] prio;
      for (int phase = 0; phase < 22; phase++) begin
         case (phase % 8)
            0:       write_capacity(CAP_WIDTH'(DEPTH));
            1:       write_capacity('1);
            2:       write_capacity(CAP_WIDTH'(1));
            3:       write_capacity(CAP_WIDTH'($urandom_range(2, DEPTH - 1)));
            4:       write_capacity('0);
            5:       write_capacity(CAP_WIDTH'(DEPTH + 1));
            default: write_capacity(CAP_WIDTH'($urandom_range(0, 31)));
         endcase
         steady_sender = (phase % 4 == 3);
         burst_left    = 0;
         fill_pct = (phase % 3 == 0) ? 80 : (phase % 3 == 1) ? 55 : 30;
         for (int n = 0; n < 70; n++) begin
            cmd = ($urandom_range(0, 99) < fill_pct) ? CMD_INSERT : CMD_REMOVE;
            // Values: mostly random, now and then an extreme
            case ($urandom_range(0, 19))
               0:       value = 32'sh7FFF_FFFF;
               1:       value = 32'sh8000_0000;
               default: value = VALUE_WIDTH'($urandom());
            endcase
            // Priorities: narrow sets force ties; others span the full range or -100 to 100
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
               prio = PRIORITY_WIDTH'(int'($urandom_range(0, 4)) - 2);
            end else if (kind < 70) begin
               prio = PRIORITY_WIDTH'($urandom());
            end else if (kind < 85) begin
               case ($urandom_range(0, 3))
                  0:       prio = 16'sh7FFF;
                  1:       prio = 16'sh8000;
                  2:       prio = '0;
                  default: prio = '1;
               endcase
            end else begin
               prio = PRIORITY_WIDTH'(int'($urandom_range(0, 200)) - 100);
            end
            send_op(cmd, value, prio);
            // Pause now and then until the queue has answered everything
            if ((phase == 0 && n == 35) || $urandom_range(0, 59) == 0) wait_drained();
         end
      end
   endtask

   // Receiver: stall pattern that switches to a random mode after each random hold
   initial begin : rsp_stall_pattern
      int mode;
      int hold;
      int tick;
      mode = 0;
      hold = 0;
      tick = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            mode = $urandom_range(0, 3);
            hold = $urandom_range(30, 300);
         end
         hold--;
         tick++;
         case (mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= ($urandom_range(0, 9) < 7);
            2:       rsp_bus.ready <= (tick % 3 == 0);
            default: rsp_bus.ready <= ($urandom_range(0, 15) == 0);
         endcase
      end
   end

   // Compare each response transfer with the oldest expectation
   initial begin : rsp_checker
      queue_result_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $error("response transfer with no operation outstanding");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.ok !== want.ok) begin
                  $error("ok: expected %0b, got %0b", want.ok, rsp_bus.ok);
                  error_count++;
               end
               if (rsp_bus.head_value !== want.head_value) begin
                  $error("head_value: expected %0d, got %0d",
                         want.head_value, rsp_bus.head_value);
                  error_count++;
               end
               if (rsp_bus.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_bus.entry_count);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog
   initial begin : run_limit
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin : test_sequence
      req_bus.valid         = 1'b0;
      req_bus.cmd           = CMD_INSERT;
      req_bus.item_value    = '0;
      req_bus.item_priority = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.max_entries   = CAP_RESET;
      shadow_count    = 0;
      shadow_capacity = DEPTH;
      error_count     = 0;
      burst_left      = 0;
      steady_sender   = 1'b0;
      req_raised      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_remove();
      test_order_and_ties();
      test_capacity_limits();
      test_random_traffic();

      // Let the last responses drain, then report
      wait_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
